@@ hw/rtl/ac4x4_pkg.sv @@
// ac4x4_pkg: shared constants and types for the 4x4 anger centroid block
// no dependencies
`timescale 1ns / 1ps

package ac4x4_pkg;

    // default widths of the charge datapath and the centroid fraction
    localparam int CHARGE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // fixed port widths
    localparam int IN_CHARGE_W = 16;
    localparam int ROW_W       = 2;
    localparam int CH_W        = 4;
    localparam int POS_W       = 11;
    localparam int OUT_TOT_W   = 20;

    // rows that open and close an event
    localparam logic [ROW_W-1:0] FIRST_ROW = 2'd0;
    localparam logic [ROW_W-1:0] LAST_ROW  = 2'd3;

    // quotient bits produced per centroid (top bit flags overflow)
    localparam int Q_W = 12;
    localparam logic [Q_W-1:0] Q_POS_LIM = 12'd1023;
    localparam logic [Q_W-1:0] Q_NEG_LIM = 12'd1024;

    // saturated centroid values
    localparam logic signed [POS_W-1:0] POS_MAX = 11'sd1023;
    localparam logic signed [POS_W-1:0] NEG_MIN = -11'sd1024;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_HOLD
    } back_state_t;

endpackage

@@ hw/rtl/anger_centroid_4x4_core.sv @@
// anger_centroid_4x4_core: top level of the 4x4 anger-logic event positioning block
// depends on ac4x4_pkg, ac4x4_front, ac4x4_queue, ac4x4_back
`timescale 1ns / 1ps

// usage
//  - input channel (in_valid/in_ready) takes one detector row per item: row_index and the
//    four column charges; row 0 clears the event sums, rows 1 to 3 add onto them
//  - output channel (out_valid/out_ready) gives one result per row 3 item: flood x and y
//    with FRAC_BITS fraction bits, trigger channel, total charge and the empty flag
//  - the front accumulates a row in the cycle it is taken, so rows 0 to 2 are always
//    accepted back to back; a row 3 item is accepted while the two-entry queue has room
//  - the back runs two restoring divider lanes (x and y) in parallel, one quotient bit
//    per cycle until all Q_W quotient bits are done, then loads the output register
//  - out_valid rises when the back loads the output register, after the queue and the divider run
//  - the back takes a new event only once the output register has taken the last one,
//    so the divider lanes set the event rate; bursts of up to four events are absorbed
//    by the queue, the divider lanes and the output register
//  - a stalled receiver holds the output register; the back then waits with its next
//    result, the queue fills, and only then is a row 3 item held off
//  - reset clears the sums, peak tracker, queue and output valid

module anger_centroid_4x4_core #(
    parameter int CHARGE_BITS = ac4x4_pkg::CHARGE_BITS_DEF,
    parameter int FRAC_BITS   = ac4x4_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ac4x4_pkg::ROW_W-1:0]         row_index,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]   charge_col0,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]   charge_col1,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]   charge_col2,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]   charge_col3,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ac4x4_pkg::POS_W-1:0]  flood_x,
    output logic signed [ac4x4_pkg::POS_W-1:0]  flood_y,
    output logic [ac4x4_pkg::CH_W-1:0]          trigger_channel,
    output logic [ac4x4_pkg::OUT_TOT_W-1:0]     total_charge,
    output logic                                empty_event
);

    // accumulator widths: total grows by 4 bits over 16 channels, weighted sums by 7
    localparam int TOT_W = CHARGE_BITS + 4;
    localparam int WS_W  = CHARGE_BITS + 7;
    localparam int JOB_W = 2 * WS_W + TOT_W + ac4x4_pkg::CH_W;

    // front to queue
    logic                           push;
    logic signed [WS_W-1:0]         f_xsum;
    logic signed [WS_W-1:0]         f_ysum;
    logic [TOT_W-1:0]               f_total;
    logic [ac4x4_pkg::CH_W-1:0]     f_chan;
    logic                           q_full;

    // queue to back
    logic                           q_valid;
    logic                           q_pop;
    logic [JOB_W-1:0]               q_dout;
    logic signed [WS_W-1:0]         b_xsum;
    logic signed [WS_W-1:0]         b_ysum;
    logic [TOT_W-1:0]               b_total;
    logic [ac4x4_pkg::CH_W-1:0]     b_chan;

    // accumulate rows, hand over the finished sums on row 3
    ac4x4_front #(
        .CHARGE_BITS (CHARGE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row_index   (row_index),
        .charge_col0 (charge_col0),
        .charge_col1 (charge_col1),
        .charge_col2 (charge_col2),
        .charge_col3 (charge_col3),
        .q_full      (q_full),
        .job_valid   (push),
        .job_xsum    (f_xsum),
        .job_ysum    (f_ysum),
        .job_total   (f_total),
        .job_chan    (f_chan)
    );

    // decouples accumulation from the dividers
    ac4x4_queue #(
        .W     (JOB_W),
        .DEPTH (ac4x4_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      ({f_xsum, f_ysum, f_total, f_chan}),
        .full     (q_full),
        .rd_valid (q_valid),
        .pop      (q_pop),
        .dout     (q_dout)
    );

    assign {b_xsum, b_ysum, b_total, b_chan} = q_dout;

    // centroid division and output register
    ac4x4_back #(
        .CHARGE_BITS (CHARGE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (q_valid),
        .job_ready       (q_pop),
        .job_xsum        (b_xsum),
        .job_ysum        (b_ysum),
        .job_total       (b_total),
        .job_chan        (b_chan),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .flood_x         (flood_x),
        .flood_y         (flood_y),
        .trigger_channel (trigger_channel),
        .total_charge    (total_charge),
        .empty_event     (empty_event)
    );

endmodule

@@ hw/rtl/ac4x4_front.sv @@
// ac4x4_front: row accumulator for total charge, weighted sums and peak channel
// depends on ac4x4_pkg
`timescale 1ns / 1ps

module ac4x4_front #(
    parameter int CHARGE_BITS = ac4x4_pkg::CHARGE_BITS_DEF,
    localparam int TOT_W = CHARGE_BITS + 4,
    localparam int WS_W  = CHARGE_BITS + 7
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ac4x4_pkg::ROW_W-1:0]          row_index,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]    charge_col0,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]    charge_col1,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]    charge_col2,
    input  logic [ac4x4_pkg::IN_CHARGE_W-1:0]    charge_col3,
    input  logic                                 q_full,
    output logic                                 job_valid,
    output logic signed [WS_W-1:0]               job_xsum,
    output logic signed [WS_W-1:0]               job_ysum,
    output logic [TOT_W-1:0]                     job_total,
    output logic [ac4x4_pkg::CH_W-1:0]           job_chan
);

    logic [CHARGE_BITS-1:0]         q [4];
    logic [CHARGE_BITS+1:0]         rowsum;
    logic [CHARGE_BITS+1:0]         xp;
    logic [CHARGE_BITS+1:0]         xn;
    logic signed [CHARGE_BITS+3:0]  xrow;
    logic [CHARGE_BITS+3:0]         ymag;
    logic signed [CHARGE_BITS+4:0]  yrow;
    logic                           first;
    logic                           accept;

    logic [TOT_W-1:0]               tot_reg,  tot_next;
    logic signed [WS_W-1:0]         xs_reg,   xs_next;
    logic signed [WS_W-1:0]         ys_reg,   ys_next;
    logic [CHARGE_BITS-1:0]         mx_reg,   mx_next;
    logic [ac4x4_pkg::CH_W-1:0]     mch_reg,  mch_next;

    assign q[0] = CHARGE_BITS'(charge_col0);
    assign q[1] = CHARGE_BITS'(charge_col1);
    assign q[2] = CHARGE_BITS'(charge_col2);
    assign q[3] = CHARGE_BITS'(charge_col3);

    // a closing row needs room in the queue
    assign in_ready  = (row_index != ac4x4_pkg::LAST_ROW) || !q_full;
    assign accept    = in_valid && in_ready;
    assign first     = (row_index == ac4x4_pkg::FIRST_ROW);
    assign job_valid = accept && (row_index == ac4x4_pkg::LAST_ROW);

    // column weights 3, 1, -1, -3
    assign rowsum = (CHARGE_BITS+2)'(q[0]) + (CHARGE_BITS+2)'(q[1])
                  + (CHARGE_BITS+2)'(q[2]) + (CHARGE_BITS+2)'(q[3]);
    assign xp   = (CHARGE_BITS+2)'(q[0]) * (CHARGE_BITS+2)'(3) + (CHARGE_BITS+2)'(q[1]);
    assign xn   = (CHARGE_BITS+2)'(q[3]) * (CHARGE_BITS+2)'(3) + (CHARGE_BITS+2)'(q[2]);
    assign xrow = $signed({2'b00, xp}) - $signed({2'b00, xn});

    // row weights 3, 1, -1, -3
    assign ymag = (row_index == ac4x4_pkg::FIRST_ROW || row_index == ac4x4_pkg::LAST_ROW)
                ? ((CHARGE_BITS+4)'(rowsum) + ((CHARGE_BITS+4)'(rowsum) << 1))
                : (CHARGE_BITS+4)'(rowsum);
    assign yrow = row_index[1] ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});

    always_comb
    begin
        tot_next = (first ? '0 : tot_reg) + TOT_W'(rowsum);
        xs_next  = (first ? '0 : xs_reg) + WS_W'(xrow);
        ys_next  = (first ? '0 : ys_reg) + WS_W'(yrow);
        mx_next  = first ? '0 : mx_reg;
        mch_next = first ? '0 : mch_reg;
        // strictly greater, so the first peak in row order wins
        for (int c = 0; c < 4; c++)
        begin
            if (q[c] > mx_next)
            begin
                mx_next  = q[c];
                mch_next = {row_index, 2'(c)};
            end
        end
    end

    assign job_xsum  = xs_next;
    assign job_ysum  = ys_next;
    assign job_total = tot_next;
    assign job_chan  = mch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg <= '0;
            xs_reg  <= '0;
            ys_reg  <= '0;
            mx_reg  <= '0;
            mch_reg <= '0;
        end
        else if (accept)
        begin
            tot_reg <= tot_next;
            xs_reg  <= xs_next;
            ys_reg  <= ys_next;
            mx_reg  <= mx_next;
            mch_reg <= mch_next;
        end
    end

endmodule

@@ hw/rtl/ac4x4_queue.sv @@
// ac4x4_queue: small register queue of finished event sums
// depends on ac4x4_pkg
`timescale 1ns / 1ps

module ac4x4_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ac4x4_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    output logic         rd_valid,
    input  logic         pop,
    output logic [W-1:0] dout
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign dout     = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ hw/rtl/ac4x4_div.sv @@
// ac4x4_div: restoring divider lane, one quotient bit per cycle while step is high, signed saturating result
// depends on ac4x4_pkg
`timescale 1ns / 1ps

module ac4x4_div #(
    parameter int CHARGE_BITS = ac4x4_pkg::CHARGE_BITS_DEF,
    parameter int FRAC_BITS   = ac4x4_pkg::FRAC_BITS_DEF,
    localparam int TOT_W = CHARGE_BITS + 4,
    localparam int WS_W  = CHARGE_BITS + 7
) (
    input  logic                                clk,
    input  logic                                load,
    input  logic                                step,
    input  logic signed [WS_W-1:0]              num,
    input  logic [TOT_W-1:0]                    den,
    output logic signed [ac4x4_pkg::POS_W-1:0]  quot
);

    localparam int NUM_W = WS_W + FRAC_BITS;
    localparam int DEN_W = TOT_W + ac4x4_pkg::Q_W - 1;
    localparam int W     = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic [W-1:0]                   rem_reg;
    logic [W-1:0]                   dsh_reg;
    logic [ac4x4_pkg::Q_W-1:0]      q_reg;
    logic                           neg_reg;
    logic [WS_W-1:0]                mag;
    logic [ac4x4_pkg::Q_W-1:0]      q_neg;
    logic                           fits;

    // magnitude of the most negative sum still fits as unsigned
    assign mag   = num[WS_W-1] ? (~num + 1'b1) : num;
    assign fits  = (rem_reg >= dsh_reg);
    assign q_neg = -q_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= W'(mag) << FRAC_BITS;
            dsh_reg <= W'(den) << (ac4x4_pkg::Q_W - 1);
            q_reg   <= '0;
            neg_reg <= num[WS_W-1];
        end
        else if (step)
        begin
            rem_reg <= fits ? rem_reg - dsh_reg : rem_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[ac4x4_pkg::Q_W-2:0], fits};
        end
    end

    // top quotient bit set means the true quotient is at least 2048
    always_comb
    begin
        if (neg_reg)
        begin
            quot = (q_reg > ac4x4_pkg::Q_NEG_LIM) ? ac4x4_pkg::NEG_MIN
                                                  : ac4x4_pkg::POS_W'(q_neg);
        end
        else
        begin
            quot = (q_reg > ac4x4_pkg::Q_POS_LIM) ? ac4x4_pkg::POS_MAX
                                                  : ac4x4_pkg::POS_W'(q_reg);
        end
    end

endmodule

@@ hw/rtl/ac4x4_back.sv @@
// ac4x4_back: centroid divider control and output register
// depends on ac4x4_pkg, ac4x4_div
`timescale 1ns / 1ps

module ac4x4_back #(
    parameter int CHARGE_BITS = ac4x4_pkg::CHARGE_BITS_DEF,
    parameter int FRAC_BITS   = ac4x4_pkg::FRAC_BITS_DEF,
    localparam int TOT_W = CHARGE_BITS + 4,
    localparam int WS_W  = CHARGE_BITS + 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  logic signed [WS_W-1:0]              job_xsum,
    input  logic signed [WS_W-1:0]              job_ysum,
    input  logic [TOT_W-1:0]                    job_total,
    input  logic [ac4x4_pkg::CH_W-1:0]          job_chan,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ac4x4_pkg::POS_W-1:0]  flood_x,
    output logic signed [ac4x4_pkg::POS_W-1:0]  flood_y,
    output logic [ac4x4_pkg::CH_W-1:0]          trigger_channel,
    output logic [ac4x4_pkg::OUT_TOT_W-1:0]     total_charge,
    output logic                                empty_event
);

    localparam int CNT_W = $clog2(ac4x4_pkg::Q_W);

    ac4x4_pkg::back_state_t              st_reg, st_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [TOT_W-1:0]                    tot_reg;
    logic [ac4x4_pkg::CH_W-1:0]          ch_reg;
    logic                                load;
    logic                                step;
    logic                                out_load;
    logic                                empty;
    logic signed [ac4x4_pkg::POS_W-1:0]  lane_x;
    logic signed [ac4x4_pkg::POS_W-1:0]  lane_y;

    logic                                ovalid_reg;
    logic signed [ac4x4_pkg::POS_W-1:0]  ox_reg;
    logic signed [ac4x4_pkg::POS_W-1:0]  oy_reg;
    logic [ac4x4_pkg::CH_W-1:0]          och_reg;
    logic [ac4x4_pkg::OUT_TOT_W-1:0]     otot_reg;
    logic                                oemp_reg;

    ac4x4_div #(
        .CHARGE_BITS (CHARGE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div_x (
        .clk  (clk),
        .load (load),
        .step (step),
        .num  (job_xsum),
        .den  (job_total),
        .quot (lane_x)
    );

    ac4x4_div #(
        .CHARGE_BITS (CHARGE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div_y (
        .clk  (clk),
        .load (load),
        .step (step),
        .num  (job_ysum),
        .den  (job_total),
        .quot (lane_y)
    );

    assign empty = (tot_reg == '0);

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        load      = 1'b0;
        step      = 1'b0;
        out_load  = 1'b0;
        job_ready = 1'b0;
        unique case (st_reg)
            ac4x4_pkg::BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    load     = 1'b1;
                    cnt_next = '0;
                    st_next  = ac4x4_pkg::BK_RUN;
                end
            end
            ac4x4_pkg::BK_RUN:
            begin
                step     = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ac4x4_pkg::Q_W - 1))
                begin
                    st_next = ac4x4_pkg::BK_HOLD;
                end
            end
            ac4x4_pkg::BK_HOLD:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    st_next  = ac4x4_pkg::BK_IDLE;
                end
            end
            default:
            begin
                st_next = ac4x4_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ac4x4_pkg::BK_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tot_reg <= job_total;
            ch_reg  <= job_chan;
        end
        if (out_load)
        begin
            ox_reg   <= empty ? '0 : lane_x;
            oy_reg   <= empty ? '0 : lane_y;
            och_reg  <= ch_reg;
            otot_reg <= ac4x4_pkg::OUT_TOT_W'(tot_reg);
            oemp_reg <= empty;
        end
    end

    assign out_valid       = ovalid_reg;
    assign flood_x         = ox_reg;
    assign flood_y         = oy_reg;
    assign trigger_channel = och_reg;
    assign total_charge    = otot_reg;
    assign empty_event     = oemp_reg;

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for anger_centroid_4x4_core, 4x4 anger-logic event positioning
// depends on ac4x4_pkg and anger_centroid_4x4_core; a scoreboard class predicts each result
`timescale 1ns / 1ps

module tb;

    localparam int TOT_W      = ac4x4_pkg::CHARGE_BITS_DEF + 4;
    localparam int WSUM_W     = ac4x4_pkg::CHARGE_BITS_DEF + 7;
    localparam int N_ITEMS    = 1250;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_GAP    = 16;

    typedef struct packed {
        logic signed [ac4x4_pkg::POS_W-1:0] fx;
        logic signed [ac4x4_pkg::POS_W-1:0] fy;
        logic [ac4x4_pkg::CH_W-1:0]         trig;
        logic [ac4x4_pkg::OUT_TOT_W-1:0]    tot;
        logic                               empty;
    } flood_result_t;

    // running event sums and the queue of floods still due from the block
    class flood_scoreboard;
        logic [TOT_W-1:0]                  sum_q;
        logic signed [WSUM_W-1:0]          sum_x;
        logic signed [WSUM_W-1:0]          sum_y;
        logic [ac4x4_pkg::IN_CHARGE_W-1:0] peak_q;
        logic [ac4x4_pkg::CH_W-1:0]        peak_ch;
        flood_result_t                     floods_due[$];
        int                                errors;

        function new();
            clear_event();
            errors = 0;
        endfunction

        function void clear_event();
            sum_q   = '0;
            sum_x   = '0;
            sum_y   = '0;
            peak_q  = '0;
            peak_ch = '0;
        endfunction

        // weighted sum over total with the fraction bits, truncated toward zero, saturated
        function logic signed [ac4x4_pkg::POS_W-1:0] centroid(logic signed [WSUM_W-1:0] num,
                                                              logic [TOT_W-1:0] den);
            longint n;
            longint mag;
            longint quo;
            n   = num;
            mag = (n < 0) ? -n : n;
            quo = (mag << ac4x4_pkg::FRAC_BITS_DEF) / longint'(den);
            if (n < 0)
                return (quo > longint'(ac4x4_pkg::Q_NEG_LIM)) ? ac4x4_pkg::NEG_MIN
                                                               : ac4x4_pkg::POS_W'(-quo);
            return (quo > longint'(ac4x4_pkg::Q_POS_LIM)) ? ac4x4_pkg::POS_MAX
                                                           : ac4x4_pkg::POS_W'(quo);
        endfunction

        function void add_row(logic [ac4x4_pkg::ROW_W-1:0] row,
                              logic [ac4x4_pkg::IN_CHARGE_W-1:0] c0,
                              logic [ac4x4_pkg::IN_CHARGE_W-1:0] c1,
                              logic [ac4x4_pkg::IN_CHARGE_W-1:0] c2,
                              logic [ac4x4_pkg::IN_CHARGE_W-1:0] c3);
            logic [ac4x4_pkg::IN_CHARGE_W-1:0] q [4];
            longint row_total;
            longint x_part;
            longint y_wt;
            flood_result_t r;
            q = '{c0, c1, c2, c3};
            if (row == ac4x4_pkg::FIRST_ROW)
                clear_event();
            row_total = 0;
            x_part    = 0;
            for (int c = 0; c < 4; c++)
            begin
                row_total += q[c];
                x_part    += (3 - 2 * c) * longint'(q[c]);
                if (q[c] > peak_q)
                begin
                    peak_q  = q[c];
                    peak_ch = ac4x4_pkg::CH_W'(row * 4 + c);
                end
            end
            y_wt  = 3 - 2 * longint'(row);
            sum_q = sum_q + TOT_W'(row_total);
            sum_x = sum_x + WSUM_W'(x_part);
            sum_y = sum_y + WSUM_W'(y_wt * row_total);
            if (row != ac4x4_pkg::LAST_ROW)
                return;
            r.trig = peak_ch;
            r.tot  = ac4x4_pkg::OUT_TOT_W'(sum_q);
            if (sum_q == 0)
            begin
                r.fx    = '0;
                r.fy    = '0;
                r.empty = 1'b1;
            end
            else
            begin
                r.fx    = centroid(sum_x, sum_q);
                r.fy    = centroid(sum_y, sum_q);
                r.empty = 1'b0;
            end
            floods_due.insert(floods_due.size(), r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_flood(flood_result_t got);
            flood_result_t want;
            if (floods_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual x %0d y %0d",
                         $time, got.fx, got.fy);
                return;
            end
            want = floods_due.pop_front();
            compare_field("flood_x", want.fx, got.fx);
            compare_field("flood_y", want.fy, got.fy);
            compare_field("trigger_channel", want.trig, got.trig);
            compare_field("total_charge", want.tot, got.tot);
            compare_field("empty_event", want.empty, got.empty);
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [ac4x4_pkg::ROW_W-1:0]        row_index;
    logic [ac4x4_pkg::IN_CHARGE_W-1:0]  charge_col0;
    logic [ac4x4_pkg::IN_CHARGE_W-1:0]  charge_col1;
    logic [ac4x4_pkg::IN_CHARGE_W-1:0]  charge_col2;
    logic [ac4x4_pkg::IN_CHARGE_W-1:0]  charge_col3;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [ac4x4_pkg::POS_W-1:0] flood_x;
    logic signed [ac4x4_pkg::POS_W-1:0] flood_y;
    logic [ac4x4_pkg::CH_W-1:0]         trigger_channel;
    logic [ac4x4_pkg::OUT_TOT_W-1:0]    total_charge;
    logic                               empty_event;

    flood_scoreboard sb;
    logic [ac4x4_pkg::IN_CHARGE_W-1:0] hit_grid [16];
    int  rows_sent;
    int  idle_cycles;
    bit  in_burst;
    bit  out_burst;

    anger_centroid_4x4_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .row_index       (row_index),
        .charge_col0     (charge_col0),
        .charge_col1     (charge_col1),
        .charge_col2     (charge_col2),
        .charge_col3     (charge_col3),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .flood_x         (flood_x),
        .flood_y         (flood_y),
        .trigger_channel (trigger_channel),
        .total_charge    (total_charge),
        .empty_event     (empty_event)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one row item: optional idle gap, then hold valid until the block takes it
    task automatic send_row(input logic [ac4x4_pkg::ROW_W-1:0] row,
                            input logic [ac4x4_pkg::IN_CHARGE_W-1:0] c0,
                            input logic [ac4x4_pkg::IN_CHARGE_W-1:0] c1,
                            input logic [ac4x4_pkg::IN_CHARGE_W-1:0] c2,
                            input logic [ac4x4_pkg::IN_CHARGE_W-1:0] c3);
        int gap;
        if ($urandom_range(0, 31) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_index   <= row;
        charge_col0 <= c0;
        charge_col1 <= c1;
        charge_col2 <= c2;
        charge_col3 <= c3;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.add_row(row, c0, c1, c2, c3);
        rows_sent++;
    endtask

    // full event from hit_grid, rows in order
    task automatic send_grid();
        for (int r = 0; r < 4; r++)
            send_row(ac4x4_pkg::ROW_W'(r), hit_grid[4 * r], hit_grid[4 * r + 1],
                     hit_grid[4 * r + 2], hit_grid[4 * r + 3]);
    endtask

    // full random, low level, or sparse hits with saturated channels
    function automatic logic [ac4x4_pkg::IN_CHARGE_W-1:0] rand_charge(int style);
        if (style == 0)
            return ac4x4_pkg::IN_CHARGE_W'($urandom);
        if (style == 1)
            return ac4x4_pkg::IN_CHARGE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: return '1;
            1: return ac4x4_pkg::IN_CHARGE_W'($urandom);
            default: return '0;
        endcase
    endfunction

    // receiver: random stall before each result, then ready until it is taken
    initial
    begin
        int stall;
        out_ready = 1'b0;
        out_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_flood('{flood_x, flood_y, trigger_channel, total_charge, empty_event});
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int style;
        sb          = new();
        rows_sent   = 0;
        in_burst    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        row_index   = '0;
        charge_col0 = '0;
        charge_col1 = '0;
        charge_col2 = '0;
        charge_col3 = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // last row with no event opened: adds onto the reset state
        send_row(ac4x4_pkg::LAST_ROW, 16'd1000, 16'd2000, 16'd0, 16'hFFFF);

        // all charges zero gives the empty flag
        foreach (hit_grid[i]) hit_grid[i] = '0;
        send_grid();

        // every channel at full scale: centered, first channel wins the tie
        foreach (hit_grid[i]) hit_grid[i] = '1;
        send_grid();

        // single small hit in the far corner
        foreach (hit_grid[i]) hit_grid[i] = '0;
        hit_grid[15] = 16'd1;
        send_grid();

        // equal peaks in two channels, the earlier one is the trigger
        foreach (hit_grid[i]) hit_grid[i] = '0;
        hit_grid[5]  = 16'd500;
        hit_grid[10] = 16'd500;
        send_grid();

        // single full-scale hit in the near corner
        foreach (hit_grid[i]) hit_grid[i] = '0;
        hit_grid[0] = '1;
        send_grid();

        // repeated last rows at full scale wrap the total and push the y centroid to saturation
        repeat (4) send_row(ac4x4_pkg::LAST_ROW, '1, '1, '1, '1);

        // mostly well-formed events with random content, some stray or repeated rows
        while (rows_sent < N_ITEMS)
        begin
            style = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < 80)
            begin
                for (int r = 0; r < 4; r++)
                    send_row(ac4x4_pkg::ROW_W'(r), rand_charge(style), rand_charge(style),
                             rand_charge(style), rand_charge(style));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_row(ac4x4_pkg::ROW_W'($urandom), rand_charge(style),
                             rand_charge(style), rand_charge(style), rand_charge(style));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then a margin past the block latency for any stray result
        while (sb.floods_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ac4x4_pkg.sv
hw/rtl/ac4x4_front.sv
hw/rtl/ac4x4_queue.sv
hw/rtl/ac4x4_div.sv
hw/rtl/ac4x4_back.sv
hw/rtl/anger_centroid_4x4_core.sv
tb/tb.sv
